// ----- hw/rtl/avcp_pkg.sv -----
package avcp_pkg;

  localparam int GAIN_W  = 8;
  localparam int EST_W   = 20;
  localparam int HOLD_W  = 21;
  localparam int DIFF_W  = 22;
  localparam int VEL_W   = 16;
  localparam int ACC_W   = 16;
  localparam int TILT_W  = 12;
  localparam int CMD_W   = 8;
  localparam int OPND_W  = 17;
  localparam int PROD_W  = 26;
  localparam int SCALE_W = 10;
  localparam int INTEG_W = 23;
  localparam int ISUM_W  = 27;
  localparam int RES_W   = 11;
  localparam int SHIFT_W = 4;
  localparam int LIM_W   = 9;

  localparam int TILT_LIMIT      = 800;
  localparam int ALT_ERR_LIMIT   = 500;
  localparam int ALT_DEADBAND    = 10;
  localparam int ALT_SHIFT       = 7;
  localparam int VEL_LIMIT       = 300;
  localparam int P_SHIFT         = 5;
  localparam int P_LIMIT         = 300;
  localparam int I_LIMIT         = 8192 * 300;
  localparam int I_SHIFT         = 13;
  localparam int D_SHIFT         = 9;
  localparam int D_LIMIT         = 150;
  localparam int DISARMED_OFFSET = 100;
  localparam int OUT_LIMIT       = 750;

  localparam logic [GAIN_W-1:0] ALT_GAIN_RST   = 8'd50;
  localparam logic [GAIN_W-1:0] VEL_P_GAIN_RST = 8'd120;
  localparam logic [GAIN_W-1:0] VEL_I_GAIN_RST = 8'd45;
  localparam logic [GAIN_W-1:0] VEL_D_GAIN_RST = 8'd1;

  typedef enum logic [1:0] {
    REG_ALT_GAIN,
    REG_VEL_P_GAIN,
    REG_VEL_I_GAIN,
    REG_VEL_D_GAIN
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_ALT,
    ST_SC_ALT,
    ST_MUL_P,
    ST_SC_P,
    ST_MUL_I,
    ST_ADD_I,
    ST_MUL_D,
    ST_SC_D,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [LIM_W-1:0]   limit;
  } scale_ctl_t;

endpackage

// ----- hw/rtl/avcp_mul.sv -----
module avcp_mul (
  input  logic                               clk,
  input  logic [avcp_pkg::GAIN_W-1:0]        gain,
  input  logic signed [avcp_pkg::OPND_W-1:0] opnd,
  output logic signed [avcp_pkg::PROD_W-1:0] prod
);
  import avcp_pkg::*;

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, gain}) * opnd;
  end

endmodule

// ----- hw/rtl/avcp_scale.sv -----
module avcp_scale (
  input  avcp_pkg::scale_ctl_t                ctl,
  input  logic signed [avcp_pkg::PROD_W-1:0]  prod,
  output logic signed [avcp_pkg::SCALE_W-1:0] scaled
);
  import avcp_pkg::*;

  logic [PROD_W:0]        bias;
  logic signed [PROD_W:0] biased;
  logic signed [PROD_W:0] quot;
  logic signed [PROD_W:0] lim;

  // shift right rounding toward zero, then saturate
  always_comb begin
    bias   = prod[PROD_W-1] ? ((PROD_W+1)'(1) << ctl.shift) - (PROD_W+1)'(1)
                            : '0;
    biased = (PROD_W+1)'(prod) + $signed(bias);
    quot   = biased >>> ctl.shift;
    lim    = $signed({{(PROD_W+1-LIM_W){1'b0}}, ctl.limit});
    if (quot > lim) begin
      scaled = SCALE_W'(lim);
    end else if (quot < -lim) begin
      scaled = SCALE_W'(-lim);
    end else begin
      scaled = SCALE_W'(quot);
    end
  end

endmodule

// ----- hw/rtl/altitude_velocity_cascade_pid.sv -----
// Cascaded altitude / velocity controller, one throttle correction per item.
// Input channel: in_valid / in_stall with the estimate, tilt, arm and mode
// fields; an item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with throttle_adjustment; one result
// per input item, in order.
// Configuration: cfg_we writes cfg_data into the gain selected by cfg_index
// (0 altitude P, 1 velocity P, 2 velocity I, 3 velocity D).
// Sequencing: after acceptance the sequencer steps through load, the altitude
// multiply and scale (altitude mode only), the velocity P, I and D steps and
// the final step; a tilted item goes from load straight to the final step.
// All products go through one registered 9x17 multiplier and one
// shift-and-saturate stage, stepped by the sequencer, so in_stall is high
// from acceptance until the sequencer returns to idle.
// A finished result waits in the output register while out_stall is high;
// the next item may be accepted meanwhile, and its result is held back in
// the sequencer until the output register is free.
// Reset: gains return to 50/120/45/1, hold target, integrator and stored
// acceleration clear to zero, and no result is pending.
module altitude_velocity_cascade_pid (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [avcp_pkg::EST_W-1:0]   est_altitude,
  input  logic signed [avcp_pkg::VEL_W-1:0]   velocity,
  input  logic signed [avcp_pkg::ACC_W-1:0]   acc_z,
  input  logic signed [avcp_pkg::TILT_W-1:0]  roll_tilt,
  input  logic signed [avcp_pkg::TILT_W-1:0]  pitch_tilt,
  input  logic                                armed,
  input  logic                                velocity_mode,
  input  logic signed [avcp_pkg::CMD_W-1:0]   commanded_velocity,
  input  logic                                capture_hold,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [avcp_pkg::RES_W-1:0]   throttle_adjustment,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [avcp_pkg::GAIN_W-1:0]         cfg_data
);
  import avcp_pkg::*;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0] alt_gain;
  logic [GAIN_W-1:0] vel_p_gain;
  logic [GAIN_W-1:0] vel_i_gain;
  logic [GAIN_W-1:0] vel_d_gain;

  logic signed [EST_W-1:0]  est;
  logic signed [VEL_W-1:0]  vel;
  logic signed [ACC_W-1:0]  acc;
  logic signed [TILT_W-1:0] roll;
  logic signed [TILT_W-1:0] pitch;
  logic                     arm;
  logic                     vmode;
  logic signed [CMD_W-1:0]  cmd;
  logic                     capture;

  logic signed [HOLD_W-1:0]  hold;
  logic signed [INTEG_W-1:0] integ;
  logic signed [ACC_W-1:0]   prev_acc;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [RES_W-1:0]   res;

  logic [GAIN_W-1:0]         mul_gain;
  logic signed [PROD_W-1:0]  prod;
  scale_ctl_t                sc_ctl;
  logic signed [SCALE_W-1:0] scaled;

  logic                      tilt_ok;
  logic signed [HOLD_W-1:0]  hold_cap;
  logic signed [HOLD_W-1:0]  hold_eff;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SCALE_W-1:0] e_cl;
  logic signed [SCALE_W-1:0] e_db;
  logic signed [OPND_W-1:0]  cmd_err;
  logic signed [OPND_W-1:0]  alt_err;
  logic signed [OPND_W-1:0]  acc_sum;
  logic signed [ISUM_W-1:0]  integ_sum;
  logic signed [INTEG_W-1:0] integ_cl;
  logic signed [INTEG_W-1:0] integ_b;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [RES_W-1:0]   i_term;
  logic                      out_free;

  avcp_mul u_mul (
    .clk  (clk),
    .gain (mul_gain),
    .opnd (opnd),
    .prod (prod)
  );

  avcp_scale u_scale (
    .ctl    (sc_ctl),
    .prod   (prod),
    .scaled (scaled)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    tilt_ok  = (roll > -TILT_LIMIT) && (roll < TILT_LIMIT) &&
               (pitch > -TILT_LIMIT) && (pitch < TILT_LIMIT);
    hold_cap = capture ? HOLD_W'(est) : hold;
    hold_eff = arm ? hold_cap : HOLD_W'(est) + HOLD_W'(DISARMED_OFFSET);
    diff     = DIFF_W'(hold_eff) - DIFF_W'(est);
    if (diff > ALT_ERR_LIMIT) begin
      e_cl = SCALE_W'(ALT_ERR_LIMIT);
    end else if (diff < -ALT_ERR_LIMIT) begin
      e_cl = SCALE_W'(-ALT_ERR_LIMIT);
    end else begin
      e_cl = SCALE_W'(diff);
    end
    if (e_cl > ALT_DEADBAND) begin
      e_db = e_cl - SCALE_W'(ALT_DEADBAND);
    end else if (e_cl < -ALT_DEADBAND) begin
      e_db = e_cl + SCALE_W'(ALT_DEADBAND);
    end else begin
      e_db = '0;
    end
    cmd_err   = OPND_W'(cmd) - OPND_W'(vel);
    alt_err   = OPND_W'(scaled) - OPND_W'(vel);
    acc_sum   = OPND_W'(acc) + OPND_W'(prev_acc);
    integ_sum = ISUM_W'(integ) + ISUM_W'(prod);
    if (integ_sum > I_LIMIT) begin
      integ_cl = INTEG_W'(I_LIMIT);
    end else if (integ_sum < -I_LIMIT) begin
      integ_cl = INTEG_W'(-I_LIMIT);
    end else begin
      integ_cl = INTEG_W'(integ_sum);
    end
    integ_b = integ + (integ[INTEG_W-1] ? INTEG_W'((1 << I_SHIFT) - 1) : '0);
    integ_q = integ_b >>> I_SHIFT;
    i_term  = RES_W'(integ_q);
  end

  always_comb begin
    case (state)
      ST_MUL_ALT: mul_gain = alt_gain;
      ST_MUL_P:   mul_gain = vel_p_gain;
      ST_MUL_I:   mul_gain = vel_i_gain;
      default:    mul_gain = vel_d_gain;
    endcase
    case (state)
      ST_SC_ALT: sc_ctl = '{shift: SHIFT_W'(ALT_SHIFT), limit: LIM_W'(VEL_LIMIT)};
      ST_SC_P:   sc_ctl = '{shift: SHIFT_W'(P_SHIFT), limit: LIM_W'(P_LIMIT)};
      default:   sc_ctl = '{shift: SHIFT_W'(D_SHIFT), limit: LIM_W'(D_LIMIT)};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!tilt_ok) begin
          state_next = ST_FIN;
        end else if (vmode) begin
          state_next = ST_MUL_P;
        end else begin
          state_next = ST_MUL_ALT;
        end
      end
      ST_MUL_ALT: state_next = ST_SC_ALT;
      ST_SC_ALT:  state_next = ST_MUL_P;
      ST_MUL_P:   state_next = ST_SC_P;
      ST_SC_P:    state_next = ST_MUL_I;
      ST_MUL_I:   state_next = ST_ADD_I;
      ST_ADD_I:   state_next = ST_MUL_D;
      ST_MUL_D:   state_next = ST_SC_D;
      ST_SC_D:    state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_gain   <= ALT_GAIN_RST;
      vel_p_gain <= VEL_P_GAIN_RST;
      vel_i_gain <= VEL_I_GAIN_RST;
      vel_d_gain <= VEL_D_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALT_GAIN:   alt_gain   <= cfg_data;
        REG_VEL_P_GAIN: vel_p_gain <= cfg_data;
        REG_VEL_I_GAIN: vel_i_gain <= cfg_data;
        REG_VEL_D_GAIN: vel_d_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      est     <= est_altitude;
      vel     <= velocity;
      acc     <= acc_z;
      roll    <= roll_tilt;
      pitch   <= pitch_tilt;
      arm     <= armed;
      vmode   <= velocity_mode;
      cmd     <= commanded_velocity;
      capture <= capture_hold;
    end
    case (state)
      ST_LOAD: begin
        if (!tilt_ok) begin
          res <= '0;
        end else if (vmode) begin
          opnd <= cmd_err;
        end else begin
          opnd <= OPND_W'(e_db);
        end
      end
      ST_SC_ALT: opnd <= alt_err;
      ST_SC_P:   res  <= RES_W'(scaled);
      ST_ADD_I:  opnd <= acc_sum;
      ST_MUL_D:  res  <= res + i_term;
      ST_SC_D:   res  <= res - RES_W'(scaled);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold     <= '0;
      integ    <= '0;
      prev_acc <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          hold <= tilt_ok ? hold_eff : hold_cap;
          if (!tilt_ok) begin
            prev_acc <= acc;
          end
        end
        ST_ADD_I: integ <= arm ? integ_cl : '0;
        ST_SC_D:  prev_acc <= acc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      throttle_adjustment <= res;
    end
  end

  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integ <= I_LIMIT) && (integ >= -I_LIMIT))
    else $error("integrator out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (throttle_adjustment <= OUT_LIMIT) &&
                  (throttle_adjustment >= -OUT_LIMIT))
    else $error("throttle adjustment out of range");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside final step");

endmodule

// ----- verif/altitude_velocity_cascade_pid_test.sv -----
module altitude_velocity_cascade_pid_test;
  import avcp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 14;

  typedef struct {
    logic signed [EST_W-1:0]  est;
    logic signed [VEL_W-1:0]  velocity;
    logic signed [ACC_W-1:0]  acc;
    logic signed [TILT_W-1:0] roll;
    logic signed [TILT_W-1:0] pitch;
    logic                     armed;
    logic                     vmode;
    logic signed [CMD_W-1:0]  cmd;
    logic                     capture;
  } sensor_item_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [EST_W-1:0]   est_altitude;
  logic signed [VEL_W-1:0]   velocity;
  logic signed [ACC_W-1:0]   acc_z;
  logic signed [TILT_W-1:0]  roll_tilt;
  logic signed [TILT_W-1:0]  pitch_tilt;
  logic                      armed;
  logic                      velocity_mode;
  logic signed [CMD_W-1:0]   commanded_velocity;
  logic                      capture_hold;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [RES_W-1:0]   throttle_adjustment;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [GAIN_W-1:0]         cfg_data;

  logic [GAIN_W-1:0]       gain_model [4];
  int                      hold_target;
  int                      integ_acc;
  int                      last_acc;
  logic signed [RES_W-1:0] throttle_expected [$];

  int mismatches;
  int cycles;
  int rx_hold_request;
  int hold_left;
  bit quiet_run;

  altitude_velocity_cascade_pid DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .est_altitude       (est_altitude),
    .velocity           (velocity),
    .acc_z              (acc_z),
    .roll_tilt          (roll_tilt),
    .pitch_tilt         (pitch_tilt),
    .armed              (armed),
    .velocity_mode      (velocity_mode),
    .commanded_velocity (commanded_velocity),
    .capture_hold       (capture_hold),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .throttle_adjustment(throttle_adjustment),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [RES_W-1:0] predict_throttle(sensor_item_t it);
    int est;
    int vel;
    int acc;
    int cmd;
    int setv;
    int e;
    int err;
    int d;
    int res;
    est = it.est;
    vel = it.velocity;
    acc = it.acc;
    cmd = it.cmd;
    res = 0;
    if (it.capture) hold_target = est;
    if (magnitude(it.roll) < TILT_LIMIT && magnitude(it.pitch) < TILT_LIMIT) begin
      if (!it.armed) hold_target = est + DISARMED_OFFSET;
      if (!it.vmode) begin
        e = clamp_int(hold_target - est, -ALT_ERR_LIMIT, ALT_ERR_LIMIT);
        if (magnitude(e) <= ALT_DEADBAND) e = 0;
        else if (e > 0) e = e - ALT_DEADBAND;
        else e = e + ALT_DEADBAND;
        setv = clamp_int(int'(gain_model[REG_ALT_GAIN]) * e / (1 << ALT_SHIFT),
                         -VEL_LIMIT, VEL_LIMIT);
      end else begin
        setv = cmd;
      end
      err = setv - vel;
      res = clamp_int(int'(gain_model[REG_VEL_P_GAIN]) * err / (1 << P_SHIFT),
                      -P_LIMIT, P_LIMIT);
      if (it.armed) integ_acc = integ_acc + int'(gain_model[REG_VEL_I_GAIN]) * err;
      else integ_acc = 0;
      integ_acc = clamp_int(integ_acc, -I_LIMIT, I_LIMIT);
      res = res + integ_acc / (1 << I_SHIFT);
      d = clamp_int(int'(gain_model[REG_VEL_D_GAIN]) * (acc + last_acc) / (1 << D_SHIFT),
                    -D_LIMIT, D_LIMIT);
      res = res - d;
    end
    last_acc = acc;
    return res[RES_W-1:0];
  endfunction

  function automatic sensor_item_t mk(int est, int vel, int acc, int roll, int pitch,
                                      bit arm, bit vmode, int cmd, bit cap);
    sensor_item_t it;
    it.est      = est[EST_W-1:0];
    it.velocity = vel[VEL_W-1:0];
    it.acc      = acc[ACC_W-1:0];
    it.roll     = roll[TILT_W-1:0];
    it.pitch    = pitch[TILT_W-1:0];
    it.armed    = arm;
    it.vmode    = vmode;
    it.cmd      = cmd[CMD_W-1:0];
    it.capture  = cap;
    return it;
  endfunction

  function automatic sensor_item_t flight_item(int base);
    int roll;
    int pitch;
    if ($urandom_range(9) == 0) begin
      roll  = int'($urandom_range(3600)) - 1800;
      pitch = int'($urandom_range(3600)) - 1800;
    end else begin
      roll  = int'($urandom_range(1000)) - 500;
      pitch = int'($urandom_range(1000)) - 500;
    end
    return mk(base + int'($urandom_range(1200)) - 600,
              int'($urandom_range(800)) - 400,
              int'($urandom_range(8000)) - 4000,
              roll, pitch,
              $urandom_range(19) != 0,
              $urandom_range(3) == 0,
              int'($urandom_range(240)) - 120,
              1'b0);
  endfunction

  function automatic sensor_item_t noise_item();
    sensor_item_t it;
    logic [31:0]  r;
    r = $urandom();
    it.est = r[EST_W-1:0];
    r = $urandom();
    it.velocity = r[15:0];
    it.acc      = r[31:16];
    r = $urandom();
    it.roll  = r[11:0];
    it.pitch = r[23:12];
    it.cmd   = r[31:24];
    r = $urandom();
    it.armed   = r[0];
    it.vmode   = r[1];
    it.capture = r[2];
    return it;
  endfunction

  task automatic send_item(sensor_item_t it);
    @(negedge clk);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) @(negedge clk);
    in_valid           <= 1'b1;
    est_altitude       <= it.est;
    velocity           <= it.velocity;
    acc_z              <= it.acc;
    roll_tilt          <= it.roll;
    pitch_tilt         <= it.pitch;
    armed              <= it.armed;
    velocity_mode      <= it.vmode;
    commanded_velocity <= it.cmd;
    capture_hold       <= it.capture;
    do @(posedge clk); while (in_stall);
    throttle_expected.push_back(predict_throttle(it));
    // drop valid so the item is not taken twice
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (throttle_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gain(cfg_reg_t idx, logic [GAIN_W-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    gain_model[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_gains(logic [GAIN_W-1:0] ga, logic [GAIN_W-1:0] gp,
                               logic [GAIN_W-1:0] gi, logic [GAIN_W-1:0] gd);
    set_gain(REG_ALT_GAIN, ga);
    set_gain(REG_VEL_P_GAIN, gp);
    set_gain(REG_VEL_I_GAIN, gi);
    set_gain(REG_VEL_D_GAIN, gd);
  endtask

  task automatic report_mismatch(logic signed [RES_W-1:0] want, bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("cycle %0d: unexpected throttle result %0d", cycles, throttle_adjustment);
      else
        $display("cycle %0d: throttle mismatch, expected %0d, got %0d",
                 cycles, want, throttle_adjustment);
    end
  endtask

  task automatic test_edge_cases();
    send_item(mk(0, 0, 0, 0, 0, 1, 0, 0, 1));
    send_item(mk(-10, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(-11, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(10, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(11, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(-524288, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(524287, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(mk(0, 50, 100, 799, -799, 1, 0, 0, 0));
    send_item(mk(0, 50, 200, 800, 0, 1, 0, 0, 0));
    send_item(mk(0, 50, 300, -800, 0, 1, 0, 0, 0));
    send_item(mk(0, 50, 400, 0, 800, 1, 0, 0, 0));
    send_item(mk(0, 50, 500, 0, -800, 1, 0, 0, 0));
    send_item(mk(0, 0, 0, 2047, -2048, 1, 0, 0, 0));
    send_item(mk(1234, 0, 0, 0, 0, 0, 0, 0, 0));
    // drive the integrator into its upper limit, then far negative
    send_item(mk(0, -32768, 0, 0, 0, 1, 1, 127, 0));
    send_item(mk(0, -32768, 0, 0, 0, 1, 1, 127, 0));
    send_item(mk(0, 32767, 0, 0, 0, 1, 1, -128, 0));
    send_item(mk(0, 32767, 0, 0, 0, 1, 1, -128, 0));
    send_item(mk(0, 32767, 0, 0, 0, 1, 1, -128, 0));
    send_item(mk(0, 0, 32767, 0, 0, 1, 1, 0, 0));
    send_item(mk(0, 0, 32767, 0, 0, 1, 1, 0, 0));
    send_item(mk(0, 0, -32768, 0, 0, 1, 1, 0, 0));
    send_item(mk(0, 0, -32768, 0, 0, 0, 1, 0, 0));
    send_item(mk(5000, 0, 0, 1000, 0, 1, 0, 0, 1));
    send_item(mk(5000, 32767, 0, 0, 0, 1, 0, 0, 0));
  endtask

  task automatic test_gain_settings();
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: set_all_gains(8'd0, 8'd0, 8'd0, 8'd0);
        1: set_all_gains(8'd255, 8'd255, 8'd255, 8'd255);
        default: set_all_gains(8'd1, 8'd255, 8'd0, 8'd128);
      endcase
      send_item(mk(-524288, -32768, -32768, 0, 0, 1, 0, 0, 1));
      send_item(mk(524287, 32767, 32767, 0, 0, 1, 0, 0, 0));
      for (int k = 0; k < 15; k++) send_item(flight_item(-200000));
    end
  endtask

  task automatic test_backpressure();
    sensor_item_t it;
    it = flight_item(30000);
    it.capture = 1'b1;
    send_item(it);
    rx_hold_request = 250;
    for (int k = 0; k < 10; k++) send_item(flight_item(30000));
  endtask

  task automatic test_drain_pause();
    sensor_item_t it;
    it = flight_item(-70000);
    it.capture = 1'b1;
    send_item(it);
    for (int k = 0; k < 4; k++) send_item(flight_item(-70000));
    while (throttle_expected.size() != 0) @(posedge clk);
    for (int k = 0; k < 5; k++) send_item(flight_item(-70000));
  endtask

  task automatic test_random_flight();
    sensor_item_t it;
    logic [31:0]  r;
    int           base;
    int           len;
    int           n;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 1) begin
        set_all_gains(8'd255, 8'd0, 8'd255, 8'd255);
      end else if (phase > 1) begin
        r = $urandom();
        set_all_gains(r[7:0], r[15:8], r[23:16], r[31:24]);
      end
      quiet_run = (phase == 3);
      n = 0;
      while (n < 185) begin
        if ($urandom_range(9) < 8) begin
          base = int'($urandom_range(1000000)) - 500000;
          len  = $urandom_range(20, 4);
          for (int k = 0; k < len; k++) begin
            it = flight_item(base);
            if (k == 0) it.capture = 1'b1;
            send_item(it);
          end
          n += len;
        end else begin
          send_item(noise_item());
          n++;
        end
      end
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    est_altitude       = '0;
    velocity           = '0;
    acc_z              = '0;
    roll_tilt          = '0;
    pitch_tilt         = '0;
    armed              = 1'b0;
    velocity_mode      = 1'b0;
    commanded_velocity = '0;
    capture_hold       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    gain_model[REG_ALT_GAIN]   = ALT_GAIN_RST;
    gain_model[REG_VEL_P_GAIN] = VEL_P_GAIN_RST;
    gain_model[REG_VEL_I_GAIN] = VEL_I_GAIN_RST;
    gain_model[REG_VEL_D_GAIN] = VEL_D_GAIN_RST;
    hold_target     = 0;
    integ_acc       = 0;
    last_acc        = 0;
    mismatches      = 0;
    rx_hold_request = 0;
    quiet_run       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_gain_settings();
    test_backpressure();
    test_drain_pause();
    test_random_flight();
    wait_for_drain();

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever @(negedge clk) begin
      if (rx_hold_request > 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet_run && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    logic signed [RES_W-1:0] want;
    forever @(posedge clk) begin
      if (!rst && out_valid && !out_stall) begin
        if (throttle_expected.size() == 0) begin
          report_mismatch('0, 1'b1);
        end else begin
          want = throttle_expected.pop_front();
          if (throttle_adjustment !== want) report_mismatch(want, 1'b0);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/avcp_pkg.sv
hw/rtl/avcp_mul.sv
hw/rtl/avcp_scale.sv
hw/rtl/altitude_velocity_cascade_pid.sv
verif/altitude_velocity_cascade_pid_test.sv
